>>> rtl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet/IPv4 header classifier package
// Shared constants, the frame class codes and the request and result types.
// ----------------------------------------------------------------------------
package ehc_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   localparam logic [15:0] IEEE_LIMIT = 16'd1536;
   localparam logic [15:0] ETH_IPV4   = 16'h0800;
   localparam logic [15:0] ETH_IPV6   = 16'h86DD;
   localparam logic [15:0] ETH_ARP    = 16'h0806;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [7:0] MF_MASK  = 8'b0010_0000;
   localparam logic [7:0] IHL_MASK = 8'b0000_1111;
   localparam logic [7:0] SYN_MASK = 8'b0000_0010;
   localparam logic [7:0] FIN_MASK = 8'b0000_0001;

   localparam int IP_START    = 14;
   localparam int MAC_BYTES   = 6;
   localparam int ETYPE_POS   = 12;
   localparam int IP_FRAG_OFS = 6;
   localparam int IP_PROT_OFS = 9;
   localparam int IP_SRC_OFS  = 12;
   localparam int IP_DST_OFS  = 16;
   localparam int TCP_FLG_OFS = 13;

   typedef enum logic [2:0] {
      CLASS_IEEE  = 3'd0,
      CLASS_ICMP  = 3'd1,
      CLASS_TCP   = 3'd2,
      CLASS_UDP   = 3'd3,
      CLASS_IPV4  = 3'd4,
      CLASS_IPV6  = 3'd5,
      CLASS_ARP   = 3'd6,
      CLASS_OTHER = 3'd7
   } class_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      class_type   frame_class;
      logic [15:0] length_out;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] src_port;
      logic [15:0] dest_port;
      logic        more_fragments;
      logic        syn_seen;
      logic        fin_seen;
   } rsp_type;

endpackage

>>> rtl/ehc_capture.sv
// ----------------------------------------------------------------------------
// Header field capture
// Tracks the byte position in the frame, captures header fields per byte and
// forms the frame summary from the updated fields.
// ----------------------------------------------------------------------------
module ehc_capture import ehc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type result
);

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] ether_kind_ff, ether_kind_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [7:0]  ip_protocol_ff, ip_protocol_in;
   logic [47:0] dest_mac_ff, dest_mac_in;
   logic [47:0] source_mac_ff, source_mac_in;
   logic [31:0] source_ip_ff, source_ip_in;
   logic [31:0] dest_ip_ff, dest_ip_in;
   logic [31:0] port_pair_ff, port_pair_in;
   logic [2:0]  flag_bits_ff, flag_bits_in;

   always_comb begin
      logic [7:0] b;
      logic first;
      logic [6:0] t0;
      logic [POSITION_WIDTH-1:0] t0_pos;
      logic [POSITION_WIDTH-1:0] q;
      logic is_ip, is_tcp, is_udp;
      class_type cls;

      b = req.data_byte;
      first = (pos_ff == '0);

      // clear captures and load the frame length at frame start
      held_length_in  = first ? req.frame_length : held_length_ff;
      ether_kind_in   = first ? '0 : ether_kind_ff;
      header_words_in = first ? '0 : header_words_ff;
      ip_protocol_in  = first ? '0 : ip_protocol_ff;
      dest_mac_in     = first ? '0 : dest_mac_ff;
      source_mac_in   = first ? '0 : source_mac_ff;
      source_ip_in    = first ? '0 : source_ip_ff;
      dest_ip_in      = first ? '0 : dest_ip_ff;
      port_pair_in    = first ? '0 : port_pair_ff;
      flag_bits_in    = first ? '0 : flag_bits_ff;
      pos_in          = pos_ff;
      t0              = '0;
      t0_pos          = '0;
      q               = '0;

      if (pos_ff != POS_MAX) begin
         for (int i = 0; i < MAC_BYTES; i++) begin
            if (pos_ff == POSITION_WIDTH'(i)) begin
               dest_mac_in[8*i +: 8] = dest_mac_in[8*i +: 8] | b;
            end
            if (pos_ff == POSITION_WIDTH'(MAC_BYTES + i)) begin
               source_mac_in[8*i +: 8] = source_mac_in[8*i +: 8] | b;
            end
         end
         if (pos_ff == POSITION_WIDTH'(ETYPE_POS)) begin
            ether_kind_in[15:8] = b;
         end
         if (pos_ff == POSITION_WIDTH'(ETYPE_POS + 1)) begin
            ether_kind_in[7:0] = b;
         end
         if (pos_ff >= POSITION_WIDTH'(IP_START) && ether_kind_in == ETH_IPV4) begin
            if (pos_ff == POSITION_WIDTH'(IP_START)) begin
               header_words_in = 4'(b & IHL_MASK);
            end
            if (pos_ff == POSITION_WIDTH'(IP_START + IP_FRAG_OFS) && (b & MF_MASK) != '0) begin
               flag_bits_in[2] = 1'b1;
            end
            if (pos_ff == POSITION_WIDTH'(IP_START + IP_PROT_OFS)) begin
               ip_protocol_in = b;
            end
            for (int i = 0; i < 4; i++) begin
               if (pos_ff == POSITION_WIDTH'(IP_START + IP_SRC_OFS + i)) begin
                  source_ip_in[8*(3-i) +: 8] = source_ip_in[8*(3-i) +: 8] | b;
               end
               if (pos_ff == POSITION_WIDTH'(IP_START + IP_DST_OFS + i)) begin
                  dest_ip_in[8*(3-i) +: 8] = dest_ip_in[8*(3-i) +: 8] | b;
               end
            end
            // transport header follows the IP header
            t0 = 7'(IP_START) + {1'b0, header_words_in, 2'b00};
            t0_pos = POSITION_WIDTH'(t0);
            q = pos_ff - t0_pos;
            if (pos_ff >= t0_pos) begin
               for (int i = 0; i < 4; i++) begin
                  if (q == POSITION_WIDTH'(i)) begin
                     port_pair_in[8*(3-i) +: 8] = port_pair_in[8*(3-i) +: 8] | b;
                  end
               end
               if (q == POSITION_WIDTH'(TCP_FLG_OFS)) begin
                  if ((b & SYN_MASK) != '0) begin
                     flag_bits_in[1] = 1'b1;
                  end
                  if ((b & FIN_MASK) != '0) begin
                     flag_bits_in[0] = 1'b1;
                  end
               end
            end
         end
         pos_in = pos_ff + POSITION_WIDTH'(1);
      end

      if (req.last_byte) begin
         pos_in = '0;
      end

      if (ether_kind_in < IEEE_LIMIT) begin
         cls = CLASS_IEEE;
      end else if (ether_kind_in == ETH_IPV4) begin
         if (ip_protocol_in == PROTO_ICMP) begin
            cls = CLASS_ICMP;
         end else if (ip_protocol_in == PROTO_TCP) begin
            cls = CLASS_TCP;
         end else if (ip_protocol_in == PROTO_UDP) begin
            cls = CLASS_UDP;
         end else begin
            cls = CLASS_IPV4;
         end
      end else if (ether_kind_in == ETH_IPV6) begin
         cls = CLASS_IPV6;
      end else if (ether_kind_in == ETH_ARP) begin
         cls = CLASS_ARP;
      end else begin
         cls = CLASS_OTHER;
      end

      is_ip  = (ether_kind_in == ETH_IPV4);
      is_tcp = (cls == CLASS_TCP);
      is_udp = (cls == CLASS_UDP);

      result.frame_class    = cls;
      result.length_out     = held_length_in;
      result.dest_mac       = dest_mac_in;
      result.source_mac     = source_mac_in;
      result.source_ip      = is_ip ? source_ip_in : '0;
      result.dest_ip        = is_ip ? dest_ip_in : '0;
      result.src_port       = (is_tcp || is_udp) ? port_pair_in[31:16] : '0;
      result.dest_port      = (is_tcp || is_udp) ? port_pair_in[15:0] : '0;
      result.more_fragments = is_ip & flag_bits_in[2];
      result.syn_seen       = is_tcp & flag_bits_in[1];
      result.fin_seen       = is_tcp & flag_bits_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_length_ff  <= held_length_in;
         ether_kind_ff   <= ether_kind_in;
         header_words_ff <= header_words_in;
         ip_protocol_ff  <= ip_protocol_in;
         dest_mac_ff     <= dest_mac_in;
         source_mac_ff   <= source_mac_in;
         source_ip_ff    <= source_ip_in;
         dest_ip_ff      <= dest_ip_in;
         port_pair_ff    <= port_pair_in;
         flag_bits_ff    <= flag_bits_in;
      end
   end

`ifndef ASSERT_OFF
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      step && req.last_byte |=> pos_ff == '0)
      else $error("position not rearmed after last byte");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      step && !req.last_byte && pos_ff != POS_MAX
         |=> pos_ff == $past(pos_ff) + POSITION_WIDTH'(1))
      else $error("position did not advance");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pos_ff))
      else $error("position moved without an item");
`endif

endmodule

>>> rtl/ethernet_ipv4_header_classifier_top.sv
// ----------------------------------------------------------------------------
// Ethernet/IPv4 header classifier
// Byte-wide frame parser that emits one header summary per frame.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data  (rsp_type)
//
// One byte per cycle sustained unless a stalled result holds a last byte;
// the input register holds each byte, the result register the summary.
// Reset clears the position counter and both valid flags.
// A stalled result blocks only a last byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_classifier_top import ehc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   logic    out_free;
   logic    step;
   rsp_type result;

   ehc_capture u_capture (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (req_ff),
      .result (result)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      step      = req_valid_ff && (!req_ff.last_byte || out_free);
      req_ready = !req_valid_ff || step;

      req_valid_in = req_ready ? req_valid : req_valid_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step && req_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (step && req_ff.last_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      step && req_ff.last_byte |=> rsp_valid_ff)
      else $error("no summary after last byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(step && req_ff.last_byte))
      else $error("pending summary overwritten");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !step |=> req_valid_ff && $stable(req_ff))
      else $error("held byte lost");
`endif

endmodule
